// ===== sv/smdr_pkg.sv =====
// ----------------------------------------------------------------------------
// smdr_pkg
// Shared types and constants for the signed multiply-divide rounding core.
// ----------------------------------------------------------------------------
package smdr_pkg;

  // Operand width used inside the datapath (ports stay 64 bits)
  localparam int unsigned W   = 64;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned LW  = W / 2;
  localparam int unsigned HW  = W - LW;
  localparam int unsigned DW  = 64;

  typedef enum logic [2:0] {
    MODE_UP        = 3'd0,
    MODE_DOWN      = 3'd1,
    MODE_CEILING   = 3'd2,
    MODE_FLOOR     = 3'd3,
    MODE_HALF_UP   = 3'd4,
    MODE_HALF_DOWN = 3'd5,
    MODE_HALF_EVEN = 3'd6,
    MODE_UNNEC     = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ROUND    = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Per-item side information that rides along the divider chain
  typedef struct packed {
    mode_e               mode;
    logic                sp;       // product is negative
    logic                qneg;     // product sign xor divisor sign (quotient sign)
    logic                divzero;
    logic signed [W-1:0] h;        // divisor arithmetically shifted right by one
  } side_t;

  // Partial remainder, shifting numerator/quotient word and divisor magnitude
  typedef struct packed {
    logic [W-1:0]  r;
    logic [PW-1:0] n;
    logic [W-1:0]  d;
    side_t         side;
  } div_t;

endpackage

// ===== sv/smdr_mul.sv =====
// ----------------------------------------------------------------------------
// smdr_mul
// Operand conditioning and three-stage magnitude multiplier.
// ----------------------------------------------------------------------------
module smdr_mul (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  output logic                  rdy_o,
  input  logic [smdr_pkg::DW-1:0] mcand_i,
  input  logic [smdr_pkg::DW-1:0] mplier_i,
  input  logic [smdr_pkg::DW-1:0] divisor_i,
  input  smdr_pkg::mode_e       mode_i,
  output logic                  vld_o,
  input  logic                  rdy_i,
  output smdr_pkg::div_t        dat_o
);

  localparam int unsigned W  = smdr_pkg::W;
  localparam int unsigned PW = smdr_pkg::PW;
  localparam int unsigned LW = smdr_pkg::LW;
  localparam int unsigned HW = smdr_pkg::HW;

  logic signed [W-1:0] a, b, c;
  logic [W-1:0]        am_d, bm_d, cm_d;
  smdr_pkg::side_t     side_d;

  logic                va_q, vb_q, vc_q;
  logic                ra, rb, rc;
  logic [W-1:0]        am_q, bm_q, da_q, db_q;
  smdr_pkg::side_t     sa_q, sb_q;
  logic [2*LW-1:0]     ll_q;
  logic [W-1:0]        lh_q, hl_q;
  logic [2*HW-1:0]     hh_q;
  logic [PW-1:0]       prod_d;
  smdr_pkg::div_t      out_q;

  // Take low operand bits, form magnitudes and sign info
  always_comb begin
    a = $signed(mcand_i[W-1:0]);
    b = $signed(mplier_i[W-1:0]);
    c = $signed(divisor_i[W-1:0]);
    am_d = a[W-1] ? W'(-a) : W'(a);
    bm_d = b[W-1] ? W'(-b) : W'(b);
    cm_d = c[W-1] ? W'(-c) : W'(c);
    side_d.mode    = mode_i;
    side_d.sp      = (a != '0) && (b != '0) && (a[W-1] ^ b[W-1]);
    side_d.qneg    = side_d.sp ^ c[W-1];
    side_d.divzero = (c == '0);
    side_d.h       = c >>> 1;
  end

  // Stage readiness: load when empty or downstream moves
  assign rc    = !vc_q || rdy_i;
  assign rb    = !vb_q || rc;
  assign ra    = !va_q || rb;
  assign rdy_o = ra;

  // Sum the partial products
  assign prod_d = PW'(ll_q) + (PW'(lh_q) << LW) + (PW'(hl_q) << LW)
                + (PW'(hh_q) << (2 * LW));

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ra) va_q <= vld_i;
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (ra) begin
      am_q <= am_d;
      bm_q <= bm_d;
      da_q <= cm_d;
      sa_q <= side_d;
    end
    if (rb) begin
      ll_q <= am_q[LW-1:0] * bm_q[LW-1:0];
      lh_q <= am_q[LW-1:0] * bm_q[W-1:LW];
      hl_q <= am_q[W-1:LW] * bm_q[LW-1:0];
      hh_q <= am_q[W-1:LW] * bm_q[W-1:LW];
      db_q <= da_q;
      sb_q <= sa_q;
    end
    if (rc) begin
      out_q.r    <= '0;
      out_q.n    <= prod_d;
      out_q.d    <= db_q;
      out_q.side <= sb_q;
    end
  end

  assign vld_o = vc_q;
  assign dat_o = out_q;

endmodule

// ===== sv/smdr_div_cell.sv =====
// ----------------------------------------------------------------------------
// smdr_div_cell
// One restoring-division step: shift in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
module smdr_div_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           rdy_o,
  input  smdr_pkg::div_t dat_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output smdr_pkg::div_t dat_o
);

  localparam int unsigned W  = smdr_pkg::W;
  localparam int unsigned PW = smdr_pkg::PW;

  logic [W:0]     rr;
  logic           qbit;
  smdr_pkg::div_t dat_d, dat_q;
  logic           vld_q;

  // Shift in next bit, subtract divisor when it fits
  always_comb begin
    rr    = {dat_i.r, dat_i.n[PW-1]};
    qbit  = (rr >= {1'b0, dat_i.d});
    dat_d = dat_i;
    dat_d.r = qbit ? W'(rr - {1'b0, dat_i.d}) : rr[W-1:0];
    dat_d.n = {dat_i.n[PW-2:0], qbit};
  end

  assign rdy_o = !vld_q || rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) dat_q <= dat_d;
  end

  assign vld_o = vld_q;
  assign dat_o = dat_q;

endmodule

// ===== sv/smdr_round.sv =====
// ----------------------------------------------------------------------------
// smdr_round
// Sign the quotient, pick the rounding step, range check into the output reg.
// ----------------------------------------------------------------------------
module smdr_round (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  output logic                    rdy_o,
  input  smdr_pkg::div_t          dat_i,
  output logic                    vld_o,
  input  logic                    rdy_i,
  output logic [smdr_pkg::DW-1:0] quotient_o,
  output smdr_pkg::status_e       status_o
);

  localparam int unsigned W  = smdr_pkg::W;
  localparam int unsigned PW = smdr_pkg::PW;

  logic signed [W+1:0] m_s, h_s, nh_s;
  logic                nz, odd, inc, dec;
  logic [PW-1:0]       t_d;
  smdr_pkg::status_e   pre_d;

  logic                v1_q, vo_q, r1;
  logic [PW-1:0]       t_q;
  logic                inc_q, dec_q;
  smdr_pkg::status_e   pre_q;

  logic [PW-1:0]       t2;
  logic [PW-W:0]       top;
  logic                fits;
  logic signed [W-1:0] qw;
  smdr_pkg::status_e   st_d, st_q;
  logic [smdr_pkg::DW-1:0] q_d, q_q;

  // Signed quotient, remainder tests and rounding step
  always_comb begin
    t_d  = dat_i.side.qneg ? PW'(-dat_i.n) : dat_i.n;
    nz   = (dat_i.r != '0);
    odd  = dat_i.n[0];
    m_s  = dat_i.side.sp ? -$signed({2'b00, dat_i.r}) : $signed({2'b00, dat_i.r});
    h_s  = (W+2)'(dat_i.side.h);
    nh_s = -h_s;
    inc  = 1'b0;
    dec  = 1'b0;
    if (nz) begin
      unique case (dat_i.side.mode)
        smdr_pkg::MODE_UP: begin
          inc = !dat_i.side.qneg;
          dec = dat_i.side.qneg;
        end
        smdr_pkg::MODE_DOWN: ;
        smdr_pkg::MODE_CEILING: inc = !dat_i.side.qneg;
        smdr_pkg::MODE_FLOOR:   dec = dat_i.side.qneg;
        smdr_pkg::MODE_HALF_UP: begin
          inc = !dat_i.side.sp && (m_s >= h_s);
          dec = dat_i.side.sp && (m_s <= nh_s);
        end
        smdr_pkg::MODE_HALF_DOWN: begin
          inc = !dat_i.side.sp && (m_s > h_s);
          dec = dat_i.side.sp && (m_s < nh_s);
        end
        smdr_pkg::MODE_HALF_EVEN: begin
          inc = !dat_i.side.sp && ((m_s > h_s) || ((m_s == h_s) && odd));
          dec = dat_i.side.sp && ((m_s < nh_s) || ((m_s == nh_s) && odd));
        end
        smdr_pkg::MODE_UNNEC: ;
        default: ;
      endcase
    end
    if (dat_i.side.divzero) begin
      pre_d = smdr_pkg::ST_DIVZERO;
    end else if (nz && (dat_i.side.mode == smdr_pkg::MODE_UNNEC)) begin
      pre_d = smdr_pkg::ST_ROUND;
    end else begin
      pre_d = smdr_pkg::ST_OK;
    end
  end

  // Apply step, check range, zero on error
  always_comb begin
    t2   = t_q + (dec_q ? {PW{1'b1}} : PW'(inc_q));
    top  = t2[PW-1:W-1];
    fits = (&top) || !(|top);
    qw   = $signed(t2[W-1:0]);
    if (pre_q != smdr_pkg::ST_OK) begin
      st_d = pre_q;
    end else if (!fits) begin
      st_d = smdr_pkg::ST_OVERFLOW;
    end else begin
      st_d = smdr_pkg::ST_OK;
    end
    q_d = (st_d == smdr_pkg::ST_OK) ? smdr_pkg::DW'(qw) : '0;
  end

  assign r1    = !vo_q || rdy_i;
  assign rdy_o = !v1_q || r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy_o) v1_q <= vld_i;
      if (r1)    vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      t_q   <= t_d;
      inc_q <= inc;
      dec_q <= dec;
      pre_q <= pre_d;
    end
    if (r1) begin
      q_q  <= q_d;
      st_q <= st_d;
    end
  end

  assign vld_o      = vo_q;
  assign quotient_o = q_q;
  assign status_o   = st_q;

endmodule

// ===== sv/signed_muldiv_with_rounding_core.sv =====
// ----------------------------------------------------------------------------
// signed_muldiv_with_rounding_core
// Full-width signed product divided by a signed divisor, rounded by mode.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                        | tuser
//  s_axis   | in  | multiplicand[63:0] multiplier divisor     | rounding_mode[2:0]
//  m_axis   | out | quotient[63:0]                            | status[1:0]
//
//  One item per cycle enters while the output is not stalled; the stages are three multiplier stages,
//  one divider cell per product bit (128), and two rounding/output stages.
//  Every stage has its own valid bit and loads when empty or when the stage
//  after it moves, so bubbles close up while the output is stalled.
//  Reset clears only the valid bits; no clearing pass is needed.
module signed_muldiv_with_rounding_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // multiplicand, multiplier, divisor
  input  logic [2:0]   s_axis_tuser,   // rounding_mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // quotient
  output logic [1:0]   m_axis_tuser    // status
);

  localparam int unsigned PW = smdr_pkg::PW;

  logic                   vld [PW+1];
  logic                   rdy [PW+1];
  smdr_pkg::div_t         dat [PW+1];
  smdr_pkg::status_e      status;

  // Multiplier front end
  smdr_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (s_axis_tvalid),
    .rdy_o     (s_axis_tready),
    .mcand_i   (s_axis_tdata[63:0]),
    .mplier_i  (s_axis_tdata[127:64]),
    .divisor_i (s_axis_tdata[191:128]),
    .mode_i    (smdr_pkg::mode_e'(s_axis_tuser)),
    .vld_o     (vld[0]),
    .rdy_i     (rdy[0]),
    .dat_o     (dat[0])
  );

  // Divider chain, one quotient bit per cell
  for (genvar k = 0; k < PW; k++) begin : g_cell
    smdr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[k]),
      .rdy_o  (rdy[k]),
      .dat_i  (dat[k]),
      .vld_o  (vld[k+1]),
      .rdy_i  (rdy[k+1]),
      .dat_o  (dat[k+1])
    );
  end

  // Rounding and output register
  smdr_round u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (vld[PW]),
    .rdy_o      (rdy[PW]),
    .dat_i      (dat[PW]),
    .vld_o      (m_axis_tvalid),
    .rdy_i      (m_axis_tready),
    .quotient_o (m_axis_tdata),
    .status_o   (status)
  );

  assign m_axis_tuser = status;

  // Error results carry a zero quotient
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != smdr_pkg::ST_OK) |-> (m_axis_tdata == '0))
    else $error("error status with nonzero quotient");

  // A blocked input means the whole chain is full up to the front
  a_full_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> vld[0])
    else $error("input stalled with empty multiplier output");

  // Back pressure only originates at a stalled output
  a_full_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output stall");

endmodule

// ===== dv/smdr_checker.sv =====
// ----------------------------------------------------------------------------
// smdr_checker
// Watches both stream channels of the multiply-divide core, computes the
// expected rounded quotient and status for every accepted item and compares
// them, in order, with the results the core delivers.
// ----------------------------------------------------------------------------
module smdr_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic [2:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0]       quotient;
    smdr_pkg::status_e status;
  } muldiv_res_t;

  muldiv_res_t quotient_q[$];
  int          fails;

  // Exact signed a*b/c with the selected rounding, checked against 64 bits
  function automatic muldiv_res_t muldiv_round(logic signed [63:0] a,
                                               logic signed [63:0] b,
                                               logic signed [63:0] c,
                                               smdr_pkg::mode_e mode);
    logic signed [191:0] prod, quo, rem, h;
    logic                prod_neg, quo_neg, odd;
    int                  adj;
    muldiv_res_t         res;
    res.quotient = '0;
    adj = 0;
    if (c == 0) begin
      res.status = smdr_pkg::ST_DIVZERO;
      return res;
    end
    prod     = 192'(a) * 192'(b);
    quo      = prod / 192'(c);   // truncates toward zero, remainder takes product sign
    rem      = prod % 192'(c);
    prod_neg = prod < 0;
    quo_neg  = prod_neg != (c < 0);
    h        = 192'(c) >>> 1;
    odd      = quo[0];
    if (rem != 0) begin
      case (mode)
        smdr_pkg::MODE_UP:        adj = quo_neg ? -1 : 1;
        smdr_pkg::MODE_DOWN:      adj = 0;
        smdr_pkg::MODE_CEILING:   adj = quo_neg ? 0 : 1;
        smdr_pkg::MODE_FLOOR:     adj = quo_neg ? -1 : 0;
        smdr_pkg::MODE_HALF_UP:
          adj = !prod_neg ? ((rem >= h) ? 1 : 0) : ((rem <= -h) ? -1 : 0);
        smdr_pkg::MODE_HALF_DOWN:
          adj = !prod_neg ? ((rem > h) ? 1 : 0) : ((rem < -h) ? -1 : 0);
        smdr_pkg::MODE_HALF_EVEN: begin
          if (!prod_neg) adj = (rem > h || (rem == h && odd)) ? 1 : 0;
          else           adj = (rem < -h || (rem == -h && odd)) ? -1 : 0;
        end
        default: begin
          res.status = smdr_pkg::ST_ROUND;
          return res;
        end
      endcase
    end
    quo = quo + 192'(adj);
    if (quo > 192'sh7FFFFFFFFFFFFFFF || quo < -192'sh8000000000000000) begin
      res.status = smdr_pkg::ST_OVERFLOW;
      return res;
    end
    res.quotient = quo[63:0];
    res.status   = smdr_pkg::ST_OK;
    return res;
  endfunction

  // Predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    muldiv_res_t exp_res;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        quotient_q.push_back(muldiv_round(s_axis_tdata[63:0], s_axis_tdata[127:64],
                                          s_axis_tdata[191:128],
                                          smdr_pkg::mode_e'(s_axis_tuser)));
      if (m_axis_tvalid && m_axis_tready) begin
        if (quotient_q.size() == 0) begin
          $error("result with no item outstanding: quotient %h status %0d",
                 m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          exp_res = quotient_q.pop_front();
          if (m_axis_tdata !== exp_res.quotient) begin
            $error("quotient: expected %h actual %h", exp_res.quotient, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== exp_res.status) begin
            $error("status: expected %0d actual %0d", exp_res.status, m_axis_tuser);
            fails++;
          end
        end
      end
    end
  end

  initial fails = 0;
  assign fail_count_o = fails;
  assign pending_o    = quotient_q.size();

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the multiply-divide core with directed corner items and random
// operands under varying stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 133;
  localparam int WDOG_MAX  = 20000;
  localparam logic [63:0] MIN64 = 64'h8000000000000000;
  localparam logic [63:0] MAX64 = 64'h7FFFFFFFFFFFFFFF;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;   // multiplicand, multiplier, divisor
  logic [2:0]   s_axis_tuser;   // rounding_mode
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // quotient
  logic [1:0]   m_axis_tuser;   // status
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_off;
  int           idle_cycles;

  signed_muldiv_with_rounding_core uut (.*);

  smdr_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Randomly stall the output, or hold it off entirely during the pressure test
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles in which nothing moves, outside the output hold-off
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        hold_off)
      idle_cycles <= 0;
    else if (idle_cycles >= WDOG_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // Random operand with bias toward corners and small magnitudes
  function automatic logic [63:0] rand_operand();
    case ($urandom_range(7))
      0:       return MIN64;
      1:       return MAX64;
      2:       return 64'($signed($urandom_range(20)) - 10);
      3:       return 64'($signed($urandom_range(2000)) - 1000);
      4:       return {32'($signed($urandom()) >>> 31), $urandom()};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                           smdr_pkg::mode_e mode);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {c, b, a};
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    logic [63:0] a, b, c;
    for (int i = 0; i < count; i++) begin
      a = rand_operand();
      b = rand_operand();
      c = ($urandom_range(15) == 0) ? 64'd0 : rand_operand();
      send_item(a, b, c, smdr_pkg::mode_e'($urandom_range(7)));
    end
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = smdr_pkg::MODE_UP;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off      = 1'b0;
    rst_ni        = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every mode on exact halves, both signs, and the extremes
    for (int m = 0; m < 8; m++) begin
      send_item(64'd5, 64'd1, 64'd2, smdr_pkg::mode_e'(m));
      send_item(-64'sd5, 64'd1, 64'd2, smdr_pkg::mode_e'(m));
    end
    send_item(64'd7, 64'd1, -64'sd3, smdr_pkg::MODE_HALF_EVEN);
    send_item(64'd3, 64'd4, 64'd0, smdr_pkg::MODE_DOWN);
    send_item(MIN64, 64'd1, -64'sd1, smdr_pkg::MODE_DOWN);
    send_item(MIN64, MIN64, MIN64, smdr_pkg::MODE_DOWN);
    send_item(MAX64, MAX64, MAX64, smdr_pkg::MODE_UNNEC);
    send_item(MAX64, MAX64, 64'd3, smdr_pkg::MODE_UNNEC);
    send_item(MAX64, MAX64, MIN64, smdr_pkg::MODE_HALF_UP);
    send_item(MIN64, MAX64, 64'd2, smdr_pkg::MODE_FLOOR);
    send_item(64'hFFFFFFFFFFFFFFFF, 64'd0, 64'hFFFFFFFFFFFFFFFF, smdr_pkg::MODE_CEILING);

    // Pressure: hold the output off while the input keeps offering
    hold_off <= 1'b1;
    fork
      send_random(200);
      begin
        repeat (400) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join

    send_idle_pct = 21;
    recv_idle_pct = 56;
    send_random(250);
    send_idle_pct = 56;
    recv_idle_pct = 21;
    send_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(225);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
